>>> hdl/disjoint_set_union_find_assert.svh
// ============================================================================
// Assertion macros for the disjoint-set engine
// Clocked on clk, disabled while rst_n is low.
// ============================================================================
`ifndef DISJOINT_SET_UNION_FIND_ASSERT_SVH
`define DISJOINT_SET_UNION_FIND_ASSERT_SVH

// same-cycle implication
`define DSUF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsuf: same-cycle check failed");

// next-cycle implication
`define DSUF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsuf: next-cycle check failed");

`endif

>>> hdl/dsuf_pkg.sv
// ============================================================================
// dsuf_pkg
// Types and constants shared by the disjoint-set engine modules.
// ============================================================================
package dsuf_pkg;

    localparam int ELEM_W               = 10;
    localparam int RANK_W               = 4;
    localparam int NUM_ELEMENTS_DEFAULT = 1024;

    localparam logic [RANK_W-1:0] RANK_MAX = '1;

    localparam logic OP_FIND  = 1'b0;
    localparam logic OP_UNION = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [ELEM_W-1:0] element_a;
        logic [ELEM_W-1:0] element_b;
    } req_t;

    typedef struct packed {
        logic [ELEM_W-1:0] root;
        logic              merged;
    } rsp_t;

    typedef struct packed {
        logic clr_step;
        logic load_req;
        logic sel_b;
        logic walk_start;
        logic walk_step;
        logic save_root;
        logic comp_start;
        logic comp_step;
        logic link;
        logic bump;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic walk_at_root;
        logic comp_at_root;
        logic op_union;
        logic out_free;
    } status_t;

endpackage

>>> hdl/dsuf_datapath.sv
// ============================================================================
// dsuf_datapath
// Parent/rank memory, pointer-chase registers, link logic and result word.
// ============================================================================
`include "disjoint_set_union_find_assert.svh"

module dsuf_datapath #(
    parameter int NUM_ELEMENTS = dsuf_pkg::NUM_ELEMENTS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  dsuf_pkg::req_t   req,
    output dsuf_pkg::rsp_t   rsp,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    input  dsuf_pkg::cmd_t   cmd,
    output dsuf_pkg::status_t status
);
    import dsuf_pkg::*;

    localparam int AW = $clog2(NUM_ELEMENTS);
    localparam int MW = AW + RANK_W;

    function automatic logic [AW-1:0] to_addr(input logic [ELEM_W-1:0] e);
        logic [AW+ELEM_W-1:0] w;
        w = (AW+ELEM_W)'(e);
        return w[AW-1:0];
    endfunction

    function automatic logic [ELEM_W-1:0] to_elem(input logic [AW-1:0] a);
        logic [AW+ELEM_W-1:0] w;
        w = (AW+ELEM_W)'(a);
        return w[ELEM_W-1:0];
    endfunction

    function automatic logic in_range(input logic [ELEM_W-1:0] e);
        return 32'(e) < NUM_ELEMENTS;
    endfunction

    logic [MW-1:0]     mem [NUM_ELEMENTS];
    logic [MW-1:0]     rdata_reg;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [MW-1:0]     wdata;
    logic [AW-1:0]     raddr;

    req_t              req_reg;
    logic [ELEM_W-1:0] r_reg;
    logic [ELEM_W-1:0] cur_reg;
    logic [ELEM_W-1:0] ra_reg;
    logic [ELEM_W-1:0] rb_reg;
    logic [RANK_W-1:0] rank_a_reg;
    logic [RANK_W-1:0] rank_b_reg;
    logic [AW-1:0]     clr_cnt_reg;
    rsp_t              out_reg;
    logic              out_valid_reg;

    logic [ELEM_W-1:0] start;
    logic [AW-1:0]     rd_parent;
    logic [RANK_W-1:0] rd_rank;
    logic              link_ok;
    logic              a_hi;
    logic              a_lo;
    logic [RANK_W-1:0] rank_a_inc;
    rsp_t              result;
    logic              out_free;

    assign start      = cmd.sel_b ? req_reg.element_b : req_reg.element_a;
    assign rd_parent  = rdata_reg[MW-1:RANK_W];
    assign rd_rank    = rdata_reg[RANK_W-1:0];
    assign link_ok    = in_range(ra_reg) && in_range(rb_reg) && (ra_reg != rb_reg);
    assign a_hi       = rank_a_reg > rank_b_reg;
    assign a_lo       = rank_a_reg < rank_b_reg;
    assign rank_a_inc = (rank_a_reg == RANK_MAX) ? rank_a_reg : rank_a_reg + RANK_W'(1);
    assign out_free   = !out_valid_reg || rsp_ready;

    always_comb
    begin
        result.merged = (req_reg.operation == OP_UNION) && link_ok;
        result.root   = (result.merged && a_lo) ? rb_reg : ra_reg;
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = to_addr(cur_reg);
        wdata = {to_addr(r_reg), rd_rank};
        raddr = to_addr(start);
        if (cmd.clr_step)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = {clr_cnt_reg, RANK_W'(0)};
        end
        else if (cmd.walk_step)
        begin
            raddr = rd_parent;
        end
        else if (cmd.comp_step)
        begin
            we    = 1'b1;
            raddr = rd_parent;
        end
        else if (cmd.link)
        begin
            we = link_ok;
            if (a_lo)
            begin
                waddr = to_addr(ra_reg);
                wdata = {to_addr(rb_reg), rank_a_reg};
            end
            else
            begin
                waddr = to_addr(rb_reg);
                wdata = {to_addr(ra_reg), rank_b_reg};
            end
        end
        else if (cmd.bump)
        begin
            we    = link_ok && !a_hi && !a_lo;
            waddr = to_addr(ra_reg);
            wdata = {to_addr(ra_reg), rank_a_inc};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
        if (cmd.walk_start)
        begin
            r_reg <= start;
        end
        else if (cmd.walk_step)
        begin
            r_reg <= to_elem(rd_parent);
        end
        if (cmd.comp_start)
        begin
            cur_reg <= start;
        end
        else if (cmd.comp_step)
        begin
            cur_reg <= to_elem(rd_parent);
        end
        if (cmd.save_root)
        begin
            if (cmd.sel_b)
            begin
                rb_reg     <= r_reg;
                rank_b_reg <= rd_rank;
            end
            else
            begin
                ra_reg     <= r_reg;
                rank_a_reg <= rd_rank;
            end
        end
        if (cmd.out_load)
        begin
            out_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp       = out_reg;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        status.clr_last     = clr_cnt_reg == AW'(NUM_ELEMENTS - 1);
        status.walk_at_root = !in_range(start) || (to_elem(rd_parent) == r_reg);
        status.comp_at_root = cur_reg == r_reg;
        status.op_union     = req_reg.operation == OP_UNION;
        status.out_free     = out_free;
    end

    `DSUF_ASSERT_SAME(a_load_free, cmd.out_load, out_free)
    `DSUF_ASSERT_SAME(a_comp_not_root, cmd.comp_step, cur_reg != r_reg)
    `DSUF_ASSERT_NEXT(a_load_shows, cmd.out_load, rsp_valid)

endmodule

>>> hdl/dsuf_ctrl.sv
// ============================================================================
// dsuf_ctrl
// Sequencer: clearing sweep, root walk, path rewrite, link and result load.
// ============================================================================
`include "disjoint_set_union_find_assert.svh"

module dsuf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  dsuf_pkg::status_t status,
    output dsuf_pkg::cmd_t    cmd
);
    import dsuf_pkg::*;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_FIND_BEGIN,
        ST_WALK,
        ST_COMP,
        ST_FIND_END,
        ST_LINK,
        ST_BUMP,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   sel_b_reg;
    logic   sel_b_next;

    assign req_ready = state_reg == ST_IDLE;

    always_comb
    begin
        state_next = state_reg;
        sel_b_next = sel_b_reg;
        cmd        = '0;
        cmd.sel_b  = sel_b_reg;
        case (state_reg)
            ST_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    sel_b_next   = 1'b0;
                    state_next   = ST_FIND_BEGIN;
                end
            end
            ST_FIND_BEGIN:
            begin
                cmd.walk_start = 1'b1;
                state_next     = ST_WALK;
            end
            ST_WALK:
            begin
                if (status.walk_at_root)
                begin
                    cmd.save_root  = 1'b1;
                    cmd.comp_start = 1'b1;
                    state_next     = ST_COMP;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_COMP:
            begin
                if (status.comp_at_root)
                begin
                    state_next = ST_FIND_END;
                end
                else
                begin
                    cmd.comp_step = 1'b1;
                end
            end
            ST_FIND_END:
            begin
                if (status.op_union && !sel_b_reg)
                begin
                    sel_b_next = 1'b1;
                    state_next = ST_FIND_BEGIN;
                end
                else if (status.op_union)
                begin
                    state_next = ST_LINK;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_LINK:
            begin
                cmd.link   = 1'b1;
                state_next = ST_BUMP;
            end
            ST_BUMP:
            begin
                cmd.bump   = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            sel_b_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_b_reg <= sel_b_next;
        end
    end

    `DSUF_ASSERT_NEXT(a_accept_starts_a, req_valid && req_ready, (state_reg == ST_FIND_BEGIN) && !sel_b_reg)
    `DSUF_ASSERT_SAME(a_bump_after_link, state_reg == ST_BUMP, $past(state_reg) == ST_LINK)
    `DSUF_ASSERT_SAME(a_link_after_b, state_reg == ST_LINK, status.op_union && sel_b_reg)

endmodule

>>> hdl/disjoint_set_union_find.sv
// ============================================================================
// disjoint_set_union_find
// Union-find engine with union by rank and full path compression.
// ============================================================================
// After reset the engine sweeps its parent/rank memory, one entry per cycle,
// and takes no request until the sweep ends. A request is handled one at a
// time over a memory with one write port and a registered read port: each
// pointer followed is read once in the root walk and once more in the path
// rewrite. With rank linking and compression, depths stay small. The result
// word sits in an output register, so the next request is taken while the
// previous result still waits. Indices at or above NUM_ELEMENTS act as fixed
// singleton roots.
// ============================================================================
module disjoint_set_union_find #(
    parameter int NUM_ELEMENTS = dsuf_pkg::NUM_ELEMENTS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  dsuf_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output dsuf_pkg::rsp_t rsp
);
    import dsuf_pkg::*;

    cmd_t    cmd;
    status_t status;

    dsuf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dsuf_datapath #(
        .NUM_ELEMENTS (NUM_ELEMENTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for disjoint_set_union_find
// Sends find and union request words through a valid/ready channel and
// checks every result word, in order, against a built-in disjoint-set model
// with union by rank and full path compression, or against the table answer
// where a row gives one. A short directed table comes first, then random
// requests aimed mostly at a small moving window of elements so that sets
// grow and paths get long. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dsuf_pkg::*;

    localparam int NUM_ELEMENTS  = NUM_ELEMENTS_DEFAULT;
    localparam int RANDOM_WORDS  = 580;
    localparam int CALM_WORDS    = 100;
    localparam int WINDOW_SIZE   = 48;
    localparam int WINDOW_PERIOD = 120;
    localparam int TAIL_CYCLES   = 64;
    localparam int QUIET_LIMIT   = 8000;

    typedef struct {
        req_t word;
        bit   known;
        rsp_t answer;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    logic [ELEM_W-1:0] up_link [NUM_ELEMENTS];
    logic [RANK_W-1:0] tree_rank [NUM_ELEMENTS];
    rsp_t              pending_results [$];
    plan_row_t         plan [$];
    bit                idling;
    int                mismatch_count;
    int                quiet_cycles;
    int                window_base;

    disjoint_set_union_find #(
        .NUM_ELEMENTS(NUM_ELEMENTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic int chase_root(input int e);
        int r;
        int cur;
        int nxt;
        int steps;
        if (e >= NUM_ELEMENTS)
            return e;
        r = e;
        steps = 0;
        while (steps < NUM_ELEMENTS && int'(up_link[r]) != r
               && int'(up_link[r]) < NUM_ELEMENTS)
        begin
            r = int'(up_link[r]);
            steps++;
        end
        cur = e;
        steps = 0;
        while (cur != r && steps < NUM_ELEMENTS)
        begin
            nxt = int'(up_link[cur]);
            up_link[cur] = r[ELEM_W-1:0];
            if (nxt >= NUM_ELEMENTS)
                break;
            cur = nxt;
            steps++;
        end
        return r;
    endfunction

    function automatic rsp_t resolve_request(input req_t w);
        rsp_t outcome;
        int   ra;
        int   rb;
        int   top;
        logic joined;
        ra = chase_root(int'(w.element_a));
        top = ra;
        joined = 1'b0;
        if (w.operation == OP_UNION)
        begin
            rb = chase_root(int'(w.element_b));
            if (ra < NUM_ELEMENTS && rb < NUM_ELEMENTS && ra != rb)
            begin
                joined = 1'b1;
                if (tree_rank[ra] > tree_rank[rb])
                begin
                    up_link[rb] = ra[ELEM_W-1:0];
                end
                else if (tree_rank[ra] < tree_rank[rb])
                begin
                    up_link[ra] = rb[ELEM_W-1:0];
                    top = rb;
                end
                else
                begin
                    up_link[rb] = ra[ELEM_W-1:0];
                    if (tree_rank[ra] != RANK_MAX)
                        tree_rank[ra] = tree_rank[ra] + 1'b1;
                end
            end
        end
        outcome.root = top[ELEM_W-1:0];
        outcome.merged = joined;
        return outcome;
    endfunction

    task automatic add_row(input logic op, input int a, input int b, input bit known,
                           input int root, input logic merged);
        plan_row_t row;
        row.word.operation = op;
        row.word.element_a = a[ELEM_W-1:0];
        row.word.element_b = b[ELEM_W-1:0];
        row.known = known;
        row.answer.root = root[ELEM_W-1:0];
        row.answer.merged = merged;
        plan = {plan, row};
    endtask

    // enter and leave at a falling edge
    task automatic push_word(input req_t w, input bit known, input rsp_t answer);
        rsp_t predicted;
        int   gap;
        gap = (idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        repeat (gap)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= w;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = resolve_request(w);
        if (known)
            predicted = answer;
        pending_results = {pending_results, predicted};
        @(negedge clk);
    endtask

    function automatic int pick_element();
        if ($urandom_range(0, 3) != 0)
            return window_base + $urandom_range(0, WINDOW_SIZE - 1);
        return $urandom_range(0, NUM_ELEMENTS - 1);
    endfunction

    initial
    begin
        rsp_t  none;
        req_t  w;
        for (int i = 0; i < NUM_ELEMENTS; i++)
        begin
            up_link[i] = i[ELEM_W-1:0];
            tree_rank[i] = '0;
        end
        none = '0;
        idling = 1'b1;
        window_base = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;

        add_row(OP_FIND,  0,    0,    1, 0,    1'b0);
        add_row(OP_FIND,  1023, 1023, 1, 1023, 1'b0);
        add_row(OP_UNION, 0,    1023, 1, 0,    1'b1);
        add_row(OP_UNION, 1023, 0,    1, 0,    1'b0);
        add_row(OP_UNION, 5,    5,    1, 5,    1'b0);
        add_row(OP_FIND,  1023, 0,    1, 0,    1'b0);
        add_row(OP_UNION, 1,    0,    1, 0,    1'b1);
        add_row(OP_UNION, 2,    3,    1, 2,    1'b1);
        add_row(OP_UNION, 3,    0,    1, 2,    1'b1);
        add_row(OP_FIND,  1023, 0,    0, 0,    1'b0);
        add_row(OP_FIND,  1,    682,  0, 0,    1'b0);
        add_row(OP_UNION, 682,  341,  0, 0,    1'b0);
        add_row(OP_UNION, 341,  682,  0, 0,    1'b0);
        add_row(OP_UNION, 1022, 1021, 0, 0,    1'b0);
        add_row(OP_UNION, 1020, 1022, 0, 0,    1'b0);
        add_row(OP_UNION, 1021, 1023, 0, 0,    1'b0);
        add_row(OP_FIND,  1020, 0,    0, 0,    1'b0);
        add_row(OP_UNION, 512,  511,  0, 0,    1'b0);
        add_row(OP_UNION, 511,  1023, 0, 0,    1'b0);
        add_row(OP_FIND,  512,  1023, 0, 0,    1'b0);
        add_row(OP_UNION, 341,  3,    0, 0,    1'b0);
        add_row(OP_FIND,  682,  0,    0, 0,    1'b0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
            push_word(plan[i].word, plan[i].known, plan[i].answer);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % WINDOW_PERIOD == 0)
                window_base = $urandom_range(0, NUM_ELEMENTS - WINDOW_SIZE);
            idling = (i < RANDOM_WORDS - CALM_WORDS) && ((i / 60) % 4 != 3);
            w.operation = ($urandom_range(0, 99) < 55) ? OP_UNION : OP_FIND;
            w.element_a = ELEM_W'(pick_element());
            w.element_b = ($urandom_range(0, 19) == 0) ? w.element_a
                                                       : ELEM_W'(pick_element());
            push_word(w, 1'b0, none);
        end
        req_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("disjoint_set_union_find verification clean");
        else
            $display("disjoint_set_union_find verification failed");
        $finish;
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && idling && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 13);
            @(negedge clk);
            if (stall_left > 0)
            begin
                rsp_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_t hope;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: root %0d merged %0d", rsp.root, rsp.merged);
                mismatch_count++;
            end
            else
            begin
                hope = pending_results.pop_front();
                if (rsp.root !== hope.root)
                begin
                    $error("root: expected %0d, actual %0d", hope.root, rsp.root);
                    mismatch_count++;
                end
                if (rsp.merged !== hope.merged)
                begin
                    $error("merged: expected %0d, actual %0d", hope.merged, rsp.merged);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("disjoint_set_union_find verification failed");
            $finish;
        end
    end

endmodule
